FILE: rtl/core/iida_pkg.sv
// Shared types and constants for the indexed insert/delete array.
// Used by the channel interfaces, the storage cells, the match encoder and the top level.
package iida_pkg;

   // list capacity and derived widths
   localparam int CAPACITY  = 64;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);

   // fixed field widths of the request and response
   localparam int OPC_W     = 3;
   localparam int POS_W     = 7;
   localparam int DATA_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int MIDX_W    = 6;
   localparam int CNT_OUT_W = 7;

   // width used when comparing the request position against the count
   localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;

   // match encoder grouping
   localparam int GRP_SIZE  = 8;
   localparam int GRP_W     = $clog2(GRP_SIZE);
   localparam int NGRP      = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
   localparam int PAD_W     = NGRP * GRP_SIZE;

   typedef enum logic [OPC_W-1:0] {
      OP_APPEND    = 3'd0,
      OP_PREPEND   = 3'd1,
      OP_INSERT_AT = 3'd2,
      OP_REM_FIRST = 3'd3,
      OP_REM_AT    = 3'd4,
      OP_REM_LAST  = 3'd5,
      OP_FIND      = 3'd6,
      OP_CLEAR     = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // what every cell does in a cycle
   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_INS,
      ACT_DEL
   } action_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_CMP,
      FSM_SEL
   } fsm_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      action_type               action;
      logic [CNT_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
      logic [CNT_W-1:0]         count;
      logic                     cmp_en;
   } cell_cmd_type;

   // first-match result from the encoder
   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] index;
   } find_result_type;

endpackage

FILE: rtl/core/iida_channels_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on iida_pkg for field widths.
interface iida_req_if import iida_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OPC_W-1:0]         opcode;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] item_value;

   modport source (output valid, opcode, position, item_value, input ready);
   modport sink   (input valid, opcode, position, item_value, output ready);
endinterface

interface iida_rsp_if import iida_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic                 found;
   logic [MIDX_W-1:0]    match_index;
   logic [CNT_OUT_W-1:0] count;

   modport source (output valid, status, found, match_index, count, input ready);
   modport sink   (input valid, status, found, match_index, count, output ready);
endinterface

FILE: rtl/core/indexed_insert_delete_array.sv
// Ordered list of signed 32-bit values held in a row of CAPACITY cells. Every request
// gives one response carrying status, found flag, match index and the count held after it.
// Append, prepend, insert, the three removals and clear complete in the cycle the request
// is accepted: all cells shift together in that cycle. Find registers the cell compare
// bits, then the hits of an eight-wide group encoder, then a group select's lowest match.
// One request is in flight at a time; the next is accepted as soon as the response register
// is empty or being read, so a stream sustains one request per cycle, but a find blocks new
// requests until its response is registered. No clearing pass is needed after reset.
module indexed_insert_delete_array import iida_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   iida_req_if.sink   req_chan,
   iida_rsp_if.source rsp_chan
);

   fsm_type                  state_ff;
   fsm_type                  state_in;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   status_type               rsp_status_ff;
   status_type               rsp_status_in;
   logic                     rsp_found_ff;
   logic                     rsp_found_in;
   logic [MIDX_W-1:0]        rsp_match_ff;
   logic [MIDX_W-1:0]        rsp_match_in;
   logic [CNT_OUT_W-1:0]     rsp_count_ff;
   logic [CNT_OUT_W-1:0]     rsp_count_in;

   logic                     req_fire;
   logic                     rsp_fire;
   logic                     full;
   op_type                   op;
   logic [CMP_W-1:0]         pos_w;
   logic [CMP_W-1:0]         cnt_w;
   status_type               dec_status;
   action_type               dec_action;
   logic [CNT_W-1:0]         dec_pos;
   logic [CNT_W-1:0]         dec_count;
   cell_cmd_type             cell_cmd;
   logic signed [DATA_W-1:0] cell_entry [CAPACITY];
   logic [CAPACITY-1:0]      cell_match;
   find_result_type          find_res;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign op       = op_type'(req_chan.opcode);
   assign pos_w    = CMP_W'(req_chan.position);
   assign cnt_w    = CMP_W'(count_ff);

   // request decode
   always_comb begin
      dec_status = ST_OK;
      dec_action = ACT_NONE;
      dec_pos    = '0;
      dec_count  = count_ff;
      unique case (op)
         OP_APPEND: begin
            if (full) begin
               dec_status = ST_FULL;
            end else begin
               dec_action = ACT_INS;
               dec_pos    = count_ff;
               dec_count  = count_ff + 1'b1;
            end
         end
         OP_PREPEND: begin
            if (full) begin
               dec_status = ST_FULL;
            end else begin
               dec_action = ACT_INS;
               dec_count  = count_ff + 1'b1;
            end
         end
         OP_INSERT_AT: begin
            if (pos_w > cnt_w) begin
               dec_status = ST_RANGE;
            end else if (full) begin
               dec_status = ST_FULL;
            end else begin
               dec_action = ACT_INS;
               dec_pos    = CNT_W'(req_chan.position);
               dec_count  = count_ff + 1'b1;
            end
         end
         OP_REM_FIRST: begin
            if (count_ff != '0) begin
               dec_action = ACT_DEL;
               dec_count  = count_ff - 1'b1;
            end
         end
         OP_REM_AT: begin
            if (pos_w >= cnt_w) begin
               dec_status = ST_RANGE;
            end else begin
               dec_action = ACT_DEL;
               dec_pos    = CNT_W'(req_chan.position);
               dec_count  = count_ff - 1'b1;
            end
         end
         OP_REM_LAST: begin
            if (count_ff != '0) begin
               dec_count = count_ff - 1'b1;
            end
         end
         OP_FIND: begin
            dec_count = count_ff;
         end
         OP_CLEAR: begin
            dec_count = '0;
         end
         default: begin
            dec_count = count_ff;
         end
      endcase
   end

   // broadcast to the cells
   always_comb begin
      cell_cmd.action = req_fire ? dec_action : ACT_NONE;
      cell_cmd.pos    = dec_pos;
      cell_cmd.value  = req_chan.item_value;
      cell_cmd.count  = count_ff;
      cell_cmd.cmp_en = req_fire && (op == OP_FIND);
   end

   // row of cells, each wired to its neighbours
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_entry;
      logic signed [DATA_W-1:0] right_entry;

      if (i == 0) begin : g_first
         assign left_entry = cell_entry[i];
      end else begin : g_left
         assign left_entry = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_right
         assign right_entry = cell_entry[i+1];
      end

      iida_cell u_cell (
         .clock       (clock),
         .cmd         (cell_cmd),
         .my_index    (IDX_W'(i)),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .match       (cell_match[i])
      );
   end

   iida_find u_find (
      .clock     (clock),
      .load      (state_ff == FSM_CMP),
      .match_vec (cell_match),
      .result    (find_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_fire && (op == OP_FIND)) begin
               state_in = FSM_CMP;
            end
         end
         FSM_CMP: begin
            state_in = FSM_SEL;
         end
         FSM_SEL: begin
            state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = (state_ff == FSM_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   end

   // count and response register
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_fire;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_count_in  = rsp_count_ff;
      if (req_fire && (op != OP_FIND)) begin
         count_in      = dec_count;
         rsp_valid_in  = 1'b1;
         rsp_status_in = dec_status;
         rsp_found_in  = 1'b0;
         rsp_match_in  = '0;
         rsp_count_in  = CNT_OUT_W'(dec_count);
      end else if (state_ff == FSM_SEL) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_found_in  = find_res.found;
         rsp_match_in  = MIDX_W'(find_res.index);
         rsp_count_in  = CNT_OUT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.match_index = rsp_match_ff;
   assign rsp_chan.count       = rsp_count_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("count above capacity");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_FULL) |-> count_ff == CNT_W'(CAPACITY))
      else $error("full status with room left");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> rsp_status_ff == ST_OK)
      else $error("match reported with error status");

   a_search_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff != FSM_IDLE) |-> !rsp_valid_ff && !req_chan.ready)
      else $error("response slot busy during search");

endmodule

FILE: rtl/core/iida_cell.sv
// One storage cell of the list: holds one entry and its last compare result.
// Depends on iida_pkg; neighbours are wired by the top level.
module iida_cell import iida_pkg::*; (
   input  logic                     clock,
   input  cell_cmd_type             cmd,
   input  logic [IDX_W-1:0]         my_index,
   input  logic signed [DATA_W-1:0] left_entry,
   input  logic signed [DATA_W-1:0] right_entry,
   output logic signed [DATA_W-1:0] entry,
   output logic                     match
);

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   logic                     match_ff;
   logic                     match_in;
   logic [CNT_W-1:0]         idx_w;

   assign idx_w = CNT_W'(my_index);

   // shift right on insert, shift left on removal
   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.action)
         ACT_INS: begin
            if (idx_w > cmd.pos) begin
               entry_in = left_entry;
            end else if (idx_w == cmd.pos) begin
               entry_in = cmd.value;
            end
         end
         ACT_DEL: begin
            if (idx_w >= cmd.pos) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // compare against the search value, only for held entries
   always_comb begin
      match_in = match_ff;
      if (cmd.cmp_en) begin
         match_in = (entry_ff == cmd.value) && (idx_w < cmd.count);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

FILE: rtl/core/iida_find.sv
// Two-level first-match encoder over the cell compare bits.
// Depends on iida_pkg; groups are encoded and registered, then the lowest group is picked.
module iida_find import iida_pkg::*; (
   input  logic                clock,
   input  logic                load,
   input  logic [CAPACITY-1:0] match_vec,
   output find_result_type     result
);

   logic [PAD_W-1:0] pad_vec;
   logic [NGRP-1:0]  grp_hit_ff;
   logic [NGRP-1:0]  grp_hit_in;
   logic [GRP_W-1:0] grp_off_ff [NGRP];
   logic [GRP_W-1:0] grp_off_in [NGRP];

   assign pad_vec = PAD_W'(match_vec);

   // lowest set bit inside each group
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_hit_in[g] = |pad_vec[g*GRP_SIZE +: GRP_SIZE];
         grp_off_in[g] = '0;
         for (int b = GRP_SIZE - 1; b >= 0; b--) begin
            if (pad_vec[g*GRP_SIZE + b]) begin
               grp_off_in[g] = GRP_W'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_hit_ff <= grp_hit_in;
         grp_off_ff <= grp_off_in;
      end
   end

   // lowest group with a hit
   always_comb begin
      result.found = |grp_hit_ff;
      result.index = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_hit_ff[g]) begin
            result.index = IDX_W'(g * GRP_SIZE) + IDX_W'(grp_off_ff[g]);
         end
      end
   end

endmodule

FILE: tb/sv/iida_list_shadow.sv
// Shadow of the indexed insert/delete array: watches both channels, keeps its own copy of
// the list, works out the response each accepted request should give and compares in order.
// Depends on iida_pkg and the channel interfaces in iida_channels_if.sv.
module iida_list_shadow import iida_pkg::*; (
   input  logic clock,
   input  logic reset,
   iida_req_if  req_chan,
   iida_rsp_if  rsp_chan,
   output int   mismatch_count,
   output int   awaited_count
);

   typedef struct packed {
      status_type           status;
      logic                 found;
      logic [MIDX_W-1:0]    match_index;
      logic [CNT_OUT_W-1:0] count;
   } list_rsp_type;

   logic signed [DATA_W-1:0] held_vals [CAPACITY];
   int                       held_len;
   list_rsp_type             awaited_rsp [$];

   // shift entries from at upwards one place right and drop v into the gap
   function automatic void open_gap(int at, logic signed [DATA_W-1:0] v);
      for (int i = held_len; i > at; i--) held_vals[i] = held_vals[i-1];
      held_vals[at] = v;
      held_len++;
   endfunction

   // shift entries above at one place left
   function automatic void close_gap(int at);
      for (int i = at; i + 1 < held_len; i++) held_vals[i] = held_vals[i+1];
      held_len--;
   endfunction

   // apply one request to the shadow list and return the response it should give
   function automatic list_rsp_type apply_list_op(op_type op, logic [POS_W-1:0] pos,
                                                  logic signed [DATA_W-1:0] val);
      list_rsp_type r;
      logic         full;
      int           p;
      r = '0;
      r.status = ST_OK;
      full = (held_len >= CAPACITY);
      p = int'(pos);
      case (op)
         OP_APPEND: begin
            if (full) r.status = ST_FULL;
            else open_gap(held_len, val);
         end
         OP_PREPEND: begin
            if (full) r.status = ST_FULL;
            else open_gap(0, val);
         end
         // range is checked before fullness
         OP_INSERT_AT: begin
            if (p > held_len) r.status = ST_RANGE;
            else if (full) r.status = ST_FULL;
            else open_gap(p, val);
         end
         OP_REM_FIRST: begin
            if (held_len > 0) close_gap(0);
         end
         OP_REM_AT: begin
            if (p >= held_len) r.status = ST_RANGE;
            else close_gap(p);
         end
         OP_REM_LAST: begin
            if (held_len > 0) held_len--;
         end
         // lowest matching index wins
         OP_FIND: begin
            for (int i = 0; i < held_len; i++) begin
               if (!r.found && held_vals[i] == val) begin
                  r.found = 1'b1;
                  r.match_index = MIDX_W'(i);
               end
            end
         end
         default: begin
            held_len = 0;
         end
      endcase
      r.count = CNT_OUT_W'(held_len);
      return r;
   endfunction

   // responses are matched before requests so a same-edge request never pairs with them
   always @(posedge clock) begin
      list_rsp_type seen;
      list_rsp_type want;
      string        act_txt;
      string        exp_txt;
      if (reset) begin
         awaited_rsp.delete();
         held_len = 0;
         mismatch_count = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.status      = status_type'(rsp_chan.status);
            seen.found       = rsp_chan.found;
            seen.match_index = rsp_chan.match_index;
            seen.count       = rsp_chan.count;
            act_txt = $sformatf("status %0d found %0d index %0d count %0d",
                                seen.status, seen.found, seen.match_index, seen.count);
            if (awaited_rsp.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %s",
                        $time, act_txt);
               mismatch_count++;
            end else begin
               want = awaited_rsp.pop_front();
               if (seen !== want) begin
                  exp_txt = $sformatf("status %0d found %0d index %0d count %0d",
                                      want.status, want.found, want.match_index,
                                      want.count);
                  $display("%0t: response mismatch, expected %s, actual %s",
                           $time, exp_txt, act_txt);
                  mismatch_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            awaited_rsp.push_back(apply_list_op(op_type'(req_chan.opcode), req_chan.position,
                                                req_chan.item_value));
      end
      awaited_count = awaited_rsp.size();
   end

endmodule

FILE: tb/sv/indexed_insert_delete_array_test.sv
// Top of the indexed insert/delete array test: clock, reset, request stimulus and response
// back-pressure, with the list shadow beside the block giving the verdict.
// Depends on iida_pkg, iida_channels_if.sv, iida_list_shadow.sv and the block itself.
module indexed_insert_delete_array_test;
   import iida_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int ITEM_TARGET = 900;

   logic clock;
   logic reset;

   iida_req_if req_chan ();
   iida_rsp_if rsp_chan ();

   int  mismatch_count;
   int  awaited_count;
   int  list_fill;
   int  sent_items;
   int  episode;
   bit  sender_steady;
   bit  receiver_steady;
   bit  hold_off_req;

   logic signed [DATA_W-1:0] value_pool [8];

   indexed_insert_delete_array dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   iida_list_shadow shadow (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

   // response back-pressure, with one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_chan.ready <= receiver_steady || ($urandom_range(99) >= 38);
         end
      end
   end

   // offer one request, wait for its acceptance and track the list fill
   task automatic issue_request(input op_type op, input int pos,
                                input logic signed [DATA_W-1:0] val);
      if (!sender_steady) begin
         while ($urandom_range(99) < 38) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid      <= 1'b1;
      req_chan.opcode     <= op;
      req_chan.position   <= POS_W'(pos);
      req_chan.item_value <= val;
      do @(posedge clock); while (!req_chan.ready);
      case (op)
         OP_APPEND, OP_PREPEND: if (list_fill < CAPACITY) list_fill++;
         OP_INSERT_AT: if (pos <= list_fill && list_fill < CAPACITY) list_fill++;
         OP_REM_FIRST, OP_REM_LAST: if (list_fill > 0) list_fill--;
         OP_REM_AT: if (pos < list_fill) list_fill--;
         OP_CLEAR: list_fill = 0;
         default: ;
      endcase
      sent_items++;
   endtask

   // pool values half the time so that finds hit, otherwise anything
   function automatic logic signed [DATA_W-1:0] pick_value();
      if ($urandom_range(1) == 0) return value_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   // mostly in range, some at the boundary, some anywhere in the field
   function automatic int pick_pos(bit for_insert);
      int limit;
      int r;
      limit = for_insert ? list_fill : list_fill - 1;
      r = $urandom_range(99);
      if (r < 70) return (limit >= 0) ? $urandom_range(limit) : 0;
      if (r < 85) return list_fill + $urandom_range(1);
      return $urandom_range(127);
   endfunction

   // weighted mix of every operation, growing on balance
   task automatic mixed_burst(input int n);
      int r;
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 20)      issue_request(OP_APPEND, pick_pos(1'b1), pick_value());
         else if (r < 30) issue_request(OP_PREPEND, pick_pos(1'b1), pick_value());
         else if (r < 50) issue_request(OP_INSERT_AT, pick_pos(1'b1), pick_value());
         else if (r < 58) issue_request(OP_REM_FIRST, pick_pos(1'b0), pick_value());
         else if (r < 72) issue_request(OP_REM_AT, pick_pos(1'b0), pick_value());
         else if (r < 80) issue_request(OP_REM_LAST, pick_pos(1'b0), pick_value());
         else if (r < 98) issue_request(OP_FIND, pick_pos(1'b0), pick_value());
         else             issue_request(OP_CLEAR, pick_pos(1'b0), pick_value());
      end
   endtask

   // fill to capacity, then probe the full list
   task automatic fill_burst();
      int r;
      while (list_fill < CAPACITY) begin
         r = $urandom_range(2);
         if (r == 0)      issue_request(OP_APPEND, 0, pick_value());
         else if (r == 1) issue_request(OP_PREPEND, 0, pick_value());
         else             issue_request(OP_INSERT_AT, $urandom_range(list_fill), pick_value());
      end
      issue_request(OP_APPEND, 0, pick_value());
      issue_request(OP_PREPEND, 0, pick_value());
      issue_request(OP_INSERT_AT, list_fill, pick_value());
      issue_request(OP_INSERT_AT, $urandom_range(list_fill - 1), pick_value());
      issue_request(OP_INSERT_AT, CAPACITY + 1, pick_value());
      issue_request(OP_INSERT_AT, 127, pick_value());
      issue_request(OP_FIND, 0, pick_value());
      issue_request(OP_REM_AT, CAPACITY, pick_value());
   endtask

   // empty the list by removals mixed with finds, then remove from the empty list
   task automatic drain_burst();
      int r;
      while (list_fill > 0) begin
         r = $urandom_range(3);
         if (r == 0)      issue_request(OP_REM_FIRST, 0, pick_value());
         else if (r == 1) issue_request(OP_REM_LAST, 0, pick_value());
         else if (r == 2) issue_request(OP_REM_AT, $urandom_range(list_fill - 1), pick_value());
         else             issue_request(OP_FIND, 0, pick_value());
      end
      issue_request(OP_REM_FIRST, 0, pick_value());
      issue_request(OP_REM_LAST, 0, pick_value());
      issue_request(OP_REM_AT, 0, pick_value());
   endtask

   // stimulus and verdict
   initial begin
      reset = 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.opcode     <= OP_APPEND;
      req_chan.position   <= '0;
      req_chan.item_value <= '0;
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      hold_off_req    = 1'b0;
      list_fill  = 0;
      sent_items = 0;
      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7fff_ffff;
      value_pool[2] = 32'sh0000_0000;
      value_pool[3] = -32'sd1;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list cases, extremes, first match, range errors
      issue_request(OP_REM_FIRST, 0, 0);
      issue_request(OP_REM_LAST, 0, 0);
      issue_request(OP_REM_AT, 0, 0);
      issue_request(OP_FIND, 0, 0);
      issue_request(OP_INSERT_AT, 1, 5);
      issue_request(OP_INSERT_AT, 127, 5);
      issue_request(OP_APPEND, 0, 32'sh7fff_ffff);
      issue_request(OP_PREPEND, 127, 32'sh8000_0000);
      issue_request(OP_INSERT_AT, 1, 0);
      issue_request(OP_INSERT_AT, 3, -1);
      issue_request(OP_APPEND, 0, -1);
      issue_request(OP_FIND, 0, -1);
      issue_request(OP_FIND, 0, 12345);
      issue_request(OP_FIND, 127, 32'sh8000_0000);
      issue_request(OP_FIND, 0, 32'sh7fff_ffff);
      issue_request(OP_REM_AT, 4, 0);
      issue_request(OP_REM_AT, 4, 0);
      issue_request(OP_REM_AT, 1, 0);
      issue_request(OP_REM_FIRST, 0, 0);
      issue_request(OP_REM_LAST, 0, 0);
      issue_request(OP_APPEND, 0, 32'sh5555_5555);
      issue_request(OP_CLEAR, 127, 32'shffff_ffff);
      issue_request(OP_FIND, 0, 32'sh5555_5555);

      // sender pause until every response is in
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (awaited_count == 0);

      fill_burst();
      drain_burst();

      // long receiver hold-off while requests keep coming
      hold_off_req = 1'b1;
      mixed_burst(12);

      // stretch with no idling on either side
      sender_steady   = 1'b1;
      receiver_steady = 1'b1;
      mixed_burst(60);
      fill_burst();
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;

      episode = 0;
      while (sent_items < ITEM_TARGET) begin
         case ($urandom_range(9))
            0: fill_burst();
            1: drain_burst();
            default: mixed_burst(20);
         endcase
         episode++;
         if (episode == 8) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
            wait (awaited_count == 0);
         end
      end

      // drain and verdict
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (awaited_count == 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/iida_pkg.sv
rtl/core/iida_channels_if.sv
rtl/core/iida_cell.sv
rtl/core/iida_find.sv
rtl/core/indexed_insert_delete_array.sv
tb/sv/iida_list_shadow.sv
tb/sv/indexed_insert_delete_array_test.sv
